FILE: design/tsf_pkg.sv
// Package: shared constants, types and state encodings of the trapezoidal filter.
`timescale 1ns / 1ps
package tsf_pkg;

  localparam int MAX_LEN = 4096;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = ADDR_W + 1;

  localparam int SAMPLE_W = 16;
  localparam int STORE_W  = 17;
  localparam int TRAP_W   = 32;
  localparam int DIFF_W   = 19;
  localparam int FSUM_W   = 32;
  localparam int SSUM_W   = 64;
  localparam int BSUM_W   = 29;
  localparam int PROD_W   = 36;
  localparam int DEN_W    = 27;
  localparam int NUM_W    = 72;
  localparam int QUO_W    = 31;
  localparam int REM_W    = DEN_W + QUO_W;
  localparam int BASE_W   = 18;

  localparam int DECAY_W = 16;
  localparam int RISE_W  = 11;
  localparam int FLAT_W  = 11;
  localparam int PRE_W   = 13;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd250;
  localparam logic [RISE_W-1:0]  RISE_RST  = 11'd250;
  localparam logic [FLAT_W-1:0]  FLAT_RST  = 11'd400;
  localparam logic [PRE_W-1:0]   PRE_RST   = 13'd500;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE   = 2'd3;

  // Input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BSUM  = 9'b000000010,
    S_BDIV  = 9'b000000100,
    S_SHIFT = 9'b000001000,
    S_FREAD = 9'b000010000,
    S_FMUL  = 9'b000100000,
    S_FACC  = 9'b001000000,
    S_FMAG  = 9'b010000000,
    S_FDIV  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             rem_nz;
  } div_rsp_t;

endpackage

FILE: design/tsf_if.sv
// Interfaces: input item channel and result channel of the trapezoidal filter.
`timescale 1ns / 1ps
interface tsf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic signed [tsf_pkg::SAMPLE_W-1:0]   sample;
  logic                                  last;
  logic        [tsf_pkg::ADDR_W-1:0]     read_index;

  modport source (output valid, func, sample, last, read_index, input ready);
  modport sink (input valid, func, sample, last, read_index, output ready);
endinterface

interface tsf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsf_pkg::TRAP_W-1:0]   trap_value;
  logic                                index_valid;

  modport source (output valid, trap_value, index_valid, input ready);
  modport sink (input valid, trap_value, index_valid, output ready);
endinterface

FILE: design/tsf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tsf_div.sv
// Iterative restoring divider: 31 quotient bits, one per cycle, overflow precheck.
`timescale 1ns / 1ps
module tsf_div (
  input  logic               clk,
  input  logic               rst,
  input  tsf_pkg::div_req_t  req,
  output tsf_pkg::div_rsp_t  rsp
);

  logic [tsf_pkg::REM_W-1:0] rem;
  logic [tsf_pkg::REM_W-1:0] dsh;
  logic [tsf_pkg::QUO_W-1:0] quo;
  logic                      ovf;
  logic                      busy;
  logic                      done;
  logic [4:0]                cnt;
  logic                      take;

  assign take = (rem >= dsh);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(tsf_pkg::QUO_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient magnitude below 2^31 once the precheck passes
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[tsf_pkg::REM_W-1:0];
      dsh <= {1'b0, req.den, {(tsf_pkg::QUO_W-1){1'b0}}};
      quo <= '0;
      ovf <= (req.num >= {{(tsf_pkg::NUM_W-tsf_pkg::REM_W){1'b0}}, req.den,
                          {tsf_pkg::QUO_W{1'b0}}});
    end else if (busy) begin
      if (take) begin
        rem <= rem - dsh;
      end
      quo <= {quo[tsf_pkg::QUO_W-2:0], take};
      dsh <= {1'b0, dsh[tsf_pkg::REM_W-1:1]};
    end
  end

  assign rsp.done   = done;
  assign rsp.quo    = quo;
  assign rsp.ovf    = ovf;
  assign rsp.rem_nz = (rem != '0);

endmodule

FILE: design/trapezoidal_shaping_filter.sv
// Top level: waveform load, baseline removal, trapezoid filter pass and readout.
`timescale 1ns / 1ps
// Load items are taken one per cycle while no read result is pending and
// are written straight into the sample memory. After a read item no item is
// taken until its result, read through the registered port of the output
// memory, has been registered onto the output or, while the output is
// stalled, into a hold register and from there onto the output. The item
// carrying last starts a filter pass during which no item is accepted: the
// baseline is summed and divided, the samples are rewritten baseline-shifted,
// then for each sample four reads through the single read port of the sample
// memory form the delay-subtract term, the two running sums are updated, and
// the shared bit-serial divider normalizes the output. Results of the
// previous waveform stay readable until a new last sample arrives.
module trapezoidal_shaping_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsf_pkg::CFG_W-1:0]          cfg_data,
  tsf_in_if.sink                             data_in,
  tsf_out_if.source                          data_out
);

  // Configuration
  logic [tsf_pkg::DECAY_W-1:0] decay;
  logic [tsf_pkg::RISE_W-1:0]  rise;
  logic [tsf_pkg::FLAT_W-1:0]  flat;
  logic [tsf_pkg::PRE_W-1:0]   pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay <= tsf_pkg::DECAY_RST;
      rise  <= tsf_pkg::RISE_RST;
      flat  <= tsf_pkg::FLAT_RST;
      pre   <= tsf_pkg::PRE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsf_pkg::REG_DECAY: decay <= cfg_data;
        tsf_pkg::REG_RISE:  rise  <= cfg_data[tsf_pkg::RISE_W-1:0];
        tsf_pkg::REG_FLAT:  flat  <= cfg_data[tsf_pkg::FLAT_W-1:0];
        tsf_pkg::REG_PRE:   pre   <= cfg_data[tsf_pkg::PRE_W-1:0];
        default: ;
      endcase
    end
  end

  tsf_pkg::state_t st;

  logic [tsf_pkg::CNT_W-1:0]          lcnt;
  logic [tsf_pkg::CNT_W-1:0]          lcnt_next;
  logic [tsf_pkg::CNT_W-1:0]          wlen;
  logic [tsf_pkg::CNT_W-1:0]          idx;
  logic                               rv;
  logic signed [tsf_pkg::BSUM_W-1:0]  bsum;
  logic signed [tsf_pkg::BASE_W-1:0]  qb;
  logic                               rnz;
  logic                               wv;
  logic [tsf_pkg::ADDR_W-1:0]         wa;
  logic [tsf_pkg::CNT_W-1:0]          ncnt;
  logic [2:0]                         k;
  logic                               ken;
  logic                               ksub;
  logic signed [tsf_pkg::DIFF_W-1:0]  dacc;
  logic signed [tsf_pkg::FSUM_W-1:0]  fsum;
  logic signed [tsf_pkg::PROD_W-1:0]  prod;
  logic signed [tsf_pkg::SSUM_W-1:0]  ssum;
  logic                               ssign;
  logic                               szero;
  logic [tsf_pkg::NUM_W-1:0]          div_num;
  logic [tsf_pkg::DEN_W-1:0]          div_den;
  logic                               div_go;
  logic [tsf_pkg::DEN_W-1:0]          norm_den;

  tsf_pkg::div_req_t dreq;
  tsf_pkg::div_rsp_t drsp;

  // Memory ports
  logic                           s_we;
  logic [tsf_pkg::ADDR_W-1:0]     s_waddr;
  logic [tsf_pkg::STORE_W-1:0]    s_wdata;
  logic [tsf_pkg::ADDR_W-1:0]     s_raddr;
  logic [tsf_pkg::STORE_W-1:0]    s_rdata;
  logic                           t_we;
  logic [tsf_pkg::ADDR_W-1:0]     t_waddr;
  logic [tsf_pkg::TRAP_W-1:0]     t_wdata;
  logic [tsf_pkg::TRAP_W-1:0]     t_rdata;

  tsf_ram #(.WIDTH(tsf_pkg::STORE_W), .DEPTH(tsf_pkg::MAX_LEN)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  tsf_ram #(.WIDTH(tsf_pkg::TRAP_W), .DEPTH(tsf_pkg::MAX_LEN)) u_trap_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (data_in.read_index),
    .rdata (t_rdata)
  );

  assign dreq.start = div_go;
  assign dreq.num   = div_num;
  assign dreq.den   = div_den;

  tsf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Input handshake and readout pipeline
  logic                           pend;
  logic                           pend_iv;
  logic                           hold_valid;
  logic signed [tsf_pkg::TRAP_W-1:0] hold_val;
  logic                           hold_iv;
  logic                           out_valid;
  logic signed [tsf_pkg::TRAP_W-1:0] out_val;
  logic                           out_iv;
  logic                           in_fire;
  logic                           load_fire;
  logic                           read_fire;
  logic signed [tsf_pkg::TRAP_W-1:0] cand_val;

  assign data_in.ready = (st == tsf_pkg::S_IDLE) && !pend && !hold_valid;
  assign in_fire   = data_in.valid && data_in.ready;
  assign load_fire = in_fire && (data_in.func == tsf_pkg::FUNC_LOAD);
  assign read_fire = in_fire && (data_in.func == tsf_pkg::FUNC_READ);
  assign cand_val  = pend_iv ? $signed(t_rdata) : '0;

  assign data_out.valid       = out_valid;
  assign data_out.trap_value  = out_val;
  assign data_out.index_valid = out_iv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend <= read_fire;
      if (out_valid && !data_out.ready) begin
        if (pend) begin
          hold_valid <= 1'b1;
        end
      end else if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_valid <= pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      pend_iv <= ({1'b0, data_in.read_index} < wlen);
    end
    if (out_valid && !data_out.ready) begin
      if (pend) begin
        hold_val <= cand_val;
        hold_iv  <= pend_iv;
      end
    end else if (hold_valid) begin
      out_val <= hold_val;
      out_iv  <= hold_iv;
    end else if (pend) begin
      out_val <= cand_val;
      out_iv  <= pend_iv;
    end
  end

  // Derived filter quantities
  logic [tsf_pkg::PRE_W-1:0]          p_eff;
  logic [tsf_pkg::CNT_W-1:0]          bend;
  logic [tsf_pkg::ADDR_W-1:0]         rtop;
  logic [tsf_pkg::CNT_W-1:0]          rtrtop;
  logic [tsf_pkg::CNT_W-1:0]          addr_k;
  logic                               en_k;
  logic signed [tsf_pkg::DIFF_W-1:0]  s_ext;
  logic signed [tsf_pkg::DIFF_W-1:0]  tdiff;
  logic signed [tsf_pkg::DIFF_W-1:0]  wfull;
  logic                               winc;
  logic [tsf_pkg::BSUM_W-1:0]         bmag;
  logic [tsf_pkg::SSUM_W-1:0]         smag;
  logic signed [tsf_pkg::BASE_W-1:0]  qpos;
  logic signed [tsf_pkg::TRAP_W-1:0]  qv;
  logic signed [tsf_pkg::TRAP_W-1:0]  trap_res;

  assign p_eff  = (pre == '0) ? tsf_pkg::PRE_W'(1) : pre;
  assign bend   = (p_eff < wlen) ? p_eff : wlen;
  assign rtop   = {1'b0, flat} + {1'b0, rise};
  assign rtrtop = {1'b0, rtop} + {2'b0, rise};

  // Address and enable of the k-th tap of the delay-subtract term
  always_comb begin
    case (k)
      3'd0: begin
        addr_k = ncnt;
        en_k   = 1'b1;
      end
      3'd1: begin
        addr_k = ncnt - {2'b0, rise};
        en_k   = (ncnt >= {2'b0, rise});
      end
      3'd2: begin
        addr_k = ncnt - {1'b0, rtop};
        en_k   = (ncnt >= {1'b0, rtop});
      end
      3'd3: begin
        addr_k = ncnt - rtrtop;
        en_k   = (ncnt >= rtrtop);
      end
      default: begin
        addr_k = ncnt;
        en_k   = 1'b0;
      end
    endcase
  end

  // Baseline shift: trunc(s - B/p) from floor quotient qb and remainder flag
  assign s_ext = tsf_pkg::DIFF_W'($signed(s_rdata));
  assign tdiff = s_ext - tsf_pkg::DIFF_W'(qb);
  assign winc  = rnz && !tdiff[tsf_pkg::DIFF_W-1] && (tdiff != '0);
  assign wfull = tdiff - tsf_pkg::DIFF_W'(winc);

  assign bmag = bsum[tsf_pkg::BSUM_W-1] ? tsf_pkg::BSUM_W'(-bsum)
                                        : tsf_pkg::BSUM_W'(bsum);
  assign smag = ssum[tsf_pkg::SSUM_W-1] ? tsf_pkg::SSUM_W'(-ssum)
                                        : tsf_pkg::SSUM_W'(ssum);
  assign qpos = $signed(drsp.quo[tsf_pkg::BASE_W-1:0]);
  assign qv   = $signed({1'b0, drsp.quo});

  // Normalized output with saturation
  always_comb begin
    if (szero) begin
      trap_res = '0;
    end else if (drsp.ovf) begin
      trap_res = ssign ? {1'b1, {(tsf_pkg::TRAP_W-1){1'b0}}}
                       : {1'b0, {(tsf_pkg::TRAP_W-1){1'b1}}};
    end else begin
      trap_res = ssign ? -qv : qv;
    end
  end

  // Memory port selection
  assign lcnt_next = lcnt + tsf_pkg::CNT_W'(!lcnt[tsf_pkg::ADDR_W]);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = lcnt[tsf_pkg::ADDR_W-1:0];
    s_wdata = tsf_pkg::STORE_W'(data_in.sample);
    s_raddr = idx[tsf_pkg::ADDR_W-1:0];
    if (st == tsf_pkg::S_IDLE) begin
      s_we = load_fire && !lcnt[tsf_pkg::ADDR_W];
    end else if (st == tsf_pkg::S_SHIFT) begin
      s_we    = wv;
      s_waddr = wa;
      s_wdata = wfull[tsf_pkg::STORE_W-1:0];
    end else if (st == tsf_pkg::S_FREAD) begin
      s_raddr = addr_k[tsf_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = ncnt[tsf_pkg::ADDR_W-1:0];
    t_wdata = trap_res;
    if ((st == tsf_pkg::S_SHIFT) && (idx == '0) && (wlen != '0)) begin
      t_we    = 1'b1;
      t_waddr = '0;
      t_wdata = '0;
    end else if ((st == tsf_pkg::S_FDIV) && drsp.done) begin
      t_we = 1'b1;
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= tsf_pkg::S_IDLE;
      lcnt   <= '0;
      wlen   <= '0;
      div_go <= 1'b0;
      rv     <= 1'b0;
      wv     <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (st)
        tsf_pkg::S_IDLE: begin
          if (load_fire) begin
            if (data_in.last) begin
              wlen <= lcnt_next;
              lcnt <= '0;
              idx  <= '0;
              rv   <= 1'b0;
              bsum <= '0;
              st   <= tsf_pkg::S_BSUM;
            end else begin
              lcnt <= lcnt_next;
            end
          end
        end
        tsf_pkg::S_BSUM: begin
          if (rv) begin
            bsum <= bsum + tsf_pkg::BSUM_W'($signed(s_rdata));
          end
          if (idx < bend) begin
            idx <= idx + 1'b1;
            rv  <= 1'b1;
          end else begin
            rv <= 1'b0;
            if (!rv) begin
              div_num <= tsf_pkg::NUM_W'(bmag);
              div_den <= tsf_pkg::DEN_W'(p_eff);
              ssign   <= bsum[tsf_pkg::BSUM_W-1];
              div_go  <= 1'b1;
              st      <= tsf_pkg::S_BDIV;
            end
          end
        end
        tsf_pkg::S_BDIV: begin
          if (drsp.done) begin
            qb   <= ssign ? -qpos - tsf_pkg::BASE_W'(drsp.rem_nz) : qpos;
            rnz  <= drsp.rem_nz;
            idx  <= '0;
            wv   <= 1'b0;
            fsum <= '0;
            ssum <= '0;
            st   <= tsf_pkg::S_SHIFT;
          end
        end
        tsf_pkg::S_SHIFT: begin
          if (idx < wlen) begin
            idx <= idx + 1'b1;
            wa  <= idx[tsf_pkg::ADDR_W-1:0];
            wv  <= 1'b1;
          end else begin
            wv <= 1'b0;
            if (!wv) begin
              ncnt <= tsf_pkg::CNT_W'(1);
              k    <= '0;
              dacc <= '0;
              st   <= (wlen > tsf_pkg::CNT_W'(1)) ? tsf_pkg::S_FREAD : tsf_pkg::S_IDLE;
            end
          end
        end
        tsf_pkg::S_FREAD: begin
          // Taps 1 and 2 subtract, taps 0 and 3 add
          if ((k != 3'd0) && ken) begin
            dacc <= ksub ? dacc - s_ext : dacc + s_ext;
          end
          ken  <= en_k;
          ksub <= (k == 3'd1) || (k == 3'd2);
          k    <= k + 3'd1;
          if (k == 3'd4) begin
            st <= tsf_pkg::S_FMUL;
          end
        end
        tsf_pkg::S_FMUL: begin
          prod <= $signed({1'b0, decay}) * dacc;
          fsum <= fsum + tsf_pkg::FSUM_W'(dacc);
          st   <= tsf_pkg::S_FACC;
        end
        tsf_pkg::S_FACC: begin
          ssum <= ssum + tsf_pkg::SSUM_W'(fsum) + tsf_pkg::SSUM_W'(prod);
          st   <= tsf_pkg::S_FMAG;
        end
        tsf_pkg::S_FMAG: begin
          div_num <= {smag, 8'b0};
          div_den <= norm_den;
          ssign   <= ssum[tsf_pkg::SSUM_W-1];
          szero   <= (ssum == '0);
          div_go  <= 1'b1;
          st      <= tsf_pkg::S_FDIV;
        end
        tsf_pkg::S_FDIV: begin
          if (drsp.done) begin
            k    <= '0;
            dacc <= '0;
            ncnt <= ncnt + 1'b1;
            st   <= ((ncnt + 1'b1) < wlen) ? tsf_pkg::S_FREAD : tsf_pkg::S_IDLE;
          end
        end
        default: st <= tsf_pkg::S_IDLE;
      endcase
    end
  end

  // Normalizer decay_time * rise_time, held in a register
  always_ff @(posedge clk) begin
    norm_den <= tsf_pkg::DEN_W'(decay * rise);
  end

endmodule

FILE: tb/tsf_checker.sv
// Checker: watches the channels and config port, predicts read results and compares them.
`timescale 1ns / 1ps
module tsf_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsf_pkg::CFG_W-1:0]     cfg_data,
  tsf_in_if                             in_ch,
  tsf_out_if                            out_ch,
  output int                            errors,
  output int                            outstanding,
  output int                            reads_checked
);

  typedef struct {
    logic signed [tsf_pkg::TRAP_W-1:0] trap_value;
    logic                              index_valid;
  } read_result_t;

  // Shadow registers and stores
  logic [tsf_pkg::DECAY_W-1:0] decay_time;
  logic [tsf_pkg::RISE_W-1:0]  rise_time;
  logic [tsf_pkg::FLAT_W-1:0]  flat_top;
  logic [tsf_pkg::PRE_W-1:0]   pretrigger_len;

  int shifted_samples [tsf_pkg::MAX_LEN];
  int trap_outputs [tsf_pkg::MAX_LEN];
  int fill_count;
  int wave_len;

  read_result_t read_results_q[$];

  // Delay-subtract term at position n over the baseline-shifted samples
  function automatic longint delay_term(int n);
    int rt;
    int rtop;
    longint v;
    rt = rise_time;
    rtop = int'(flat_top) + rt;
    v = shifted_samples[n];
    if (n < rt) return v;
    v -= shifted_samples[n - rt];
    if (n < rtop) return v;
    v -= shifted_samples[n - rtop];
    if (n < rt + rtop) return v;
    v += shifted_samples[n - rt - rtop];
    return v;
  endfunction

  // Scale to Q24.8 by decay*rise, truncate, saturate
  function automatic int scale_q24_8(longint s);
    longint den;
    longint q;
    den = longint'(decay_time) * longint'(rise_time);
    if (den == 0) begin
      if (s > 0) return 32'sh7fffffff;
      if (s < 0) return 32'sh80000000;
      return 0;
    end
    q = (s * 256) / den;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return int'(q);
  endfunction

  // Baseline removal followed by the trapezoid recursion
  function automatic void filter_pass();
    longint p;
    longint bsum;
    longint fsum;
    longint ssum;
    longint d;
    p = (pretrigger_len == 0) ? 1 : pretrigger_len;
    bsum = 0;
    for (int n = 0; n < p && n < wave_len; n++) bsum += shifted_samples[n];
    for (int n = 0; n < wave_len; n++)
      shifted_samples[n] = int'((longint'(shifted_samples[n]) * p - bsum) / p);
    fsum = 0;
    ssum = 0;
    if (wave_len > 0) trap_outputs[0] = 0;
    for (int n = 1; n < wave_len; n++) begin
      d = delay_term(n);
      fsum += d;
      ssum += fsum + longint'(decay_time) * d;
      trap_outputs[n] = scale_q24_8(ssum);
    end
  endfunction

  always @(posedge clk) begin
    read_result_t exp_r;
    if (rst) begin
      decay_time = tsf_pkg::DECAY_RST;
      rise_time = tsf_pkg::RISE_RST;
      flat_top = tsf_pkg::FLAT_RST;
      pretrigger_len = tsf_pkg::PRE_RST;
      fill_count = 0;
      wave_len = 0;
      read_results_q.delete();
      errors = 0;
      outstanding = 0;
      reads_checked = 0;
    end else begin
      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          tsf_pkg::REG_DECAY: decay_time = cfg_data[tsf_pkg::DECAY_W-1:0];
          tsf_pkg::REG_RISE:  rise_time = cfg_data[tsf_pkg::RISE_W-1:0];
          tsf_pkg::REG_FLAT:  flat_top = cfg_data[tsf_pkg::FLAT_W-1:0];
          tsf_pkg::REG_PRE:   pretrigger_len = cfg_data[tsf_pkg::PRE_W-1:0];
          default: ;
        endcase
      end
      // Input transaction
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == tsf_pkg::FUNC_LOAD) begin
          if (fill_count < tsf_pkg::MAX_LEN) begin
            shifted_samples[fill_count] = int'(in_ch.sample);
            fill_count++;
          end
          if (in_ch.last) begin
            wave_len = fill_count;
            fill_count = 0;
            filter_pass();
          end
        end else begin
          if (int'(in_ch.read_index) < wave_len) begin
            exp_r.trap_value = trap_outputs[in_ch.read_index];
            exp_r.index_valid = 1'b1;
          end else begin
            exp_r.trap_value = '0;
            exp_r.index_valid = 1'b0;
          end
          read_results_q = {read_results_q, exp_r};
        end
      end
      // Result transaction
      if (out_ch.valid && out_ch.ready) begin
        if (read_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result trap_value=%0d index_valid=%0b",
                   $time, out_ch.trap_value, out_ch.index_valid);
        end else begin
          exp_r = read_results_q.pop_front();
          reads_checked++;
          if (out_ch.trap_value !== exp_r.trap_value) begin
            errors++;
            $display("%0t: trap_value expected %0d actual %0d",
                     $time, exp_r.trap_value, out_ch.trap_value);
          end
          if (out_ch.index_valid !== exp_r.index_valid) begin
            errors++;
            $display("%0t: index_valid expected %0b actual %0b",
                     $time, exp_r.index_valid, out_ch.index_valid);
          end
        end
      end
      outstanding = read_results_q.size();
    end
  end

endmodule

FILE: tb/tb_trapezoidal_shaping_filter.sv
// Testbench top: clock, reset, stimulus, idling and final verdict for the trapezoidal filter.
`timescale 1ns / 1ps
module tb_trapezoidal_shaping_filter;

  localparam int STALL_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                          cfg_we;
  logic [tsf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tsf_pkg::CFG_W-1:0]     cfg_data;

  tsf_in_if  in_ch ();
  tsf_out_if out_ch ();

  int errors;
  int outstanding;
  int reads_checked;
  int snd_idle;
  int rcv_idle;
  int items_sent;
  int waves_sent;
  int stall_cycles;

  always #1 clk = ~clk;

  trapezoidal_shaping_filter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_in   (in_ch),
    .data_out  (out_ch)
  );

  tsf_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .errors        (errors),
    .outstanding   (outstanding),
    .reads_checked (reads_checked)
  );

  // Result-side backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one item; called at a falling edge, returns at a falling edge
  task automatic put_item(logic f, logic signed [tsf_pkg::SAMPLE_W-1:0] s, logic l,
                          logic [tsf_pkg::ADDR_W-1:0] idx);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.sample <= s;
    in_ch.last <= l;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_sample(int s, logic l);
    put_item(tsf_pkg::FUNC_LOAD, tsf_pkg::SAMPLE_W'(s), l, tsf_pkg::ADDR_W'($urandom));
  endtask

  task automatic read_at(int idx);
    put_item(tsf_pkg::FUNC_READ, tsf_pkg::SAMPLE_W'($urandom), 1'($urandom),
             tsf_pkg::ADDR_W'(idx));
  endtask

  // Register writes only once all reads are back
  task automatic set_config(int decay, int rise, int flat, int pre);
    int v[4];
    v = '{decay, rise, flat, pre};
    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= tsf_pkg::CFG_IDX_W'(i);
      cfg_data <= tsf_pkg::CFG_W'(v[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int d;
    int r;
    int f;
    int p;
    case ($urandom_range(3))
      0: d = 0;
      1: d = 65535;
      default: d = $urandom_range(65535);
    endcase
    case ($urandom_range(4))
      0: r = 0;
      1: r = 2047;
      default: r = $urandom_range(1, 12);
    endcase
    case ($urandom_range(3))
      0: f = 2047;
      1: f = 0;
      default: f = $urandom_range(0, 12);
    endcase
    case ($urandom_range(5))
      0: p = 0;
      1: p = 8191;
      2: p = 4096;
      default: p = $urandom_range(1, 24);
    endcase
    set_config(d, r, f, p);
  endtask

  // One waveform (pulse on a baseline or raw noise), then reads of its outputs
  task automatic run_waveform(int len);
    int base;
    int amp;
    int t0;
    int s;
    int span;
    int nreads;
    logic raw;
    raw = ($urandom_range(9) < 3);
    base = $urandom_range(2000) - 1000;
    amp = $urandom_range(40000) - 20000;
    t0 = $urandom_range(len);
    for (int n = 0; n < len; n++) begin
      if (raw) s = $signed(16'($urandom));
      else begin
        s = base + (n >= t0 ? amp : 0) + $urandom_range(64) - 32;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
      end
      // occasional read of the previous waveform mid-load
      if ($urandom_range(19) == 0) read_at($urandom_range(tsf_pkg::MAX_LEN - 1));
      load_sample(s, n == len - 1);
    end
    waves_sent++;
    span = (len < tsf_pkg::MAX_LEN) ? len : tsf_pkg::MAX_LEN;
    nreads = $urandom_range(2, 6) + span / 2;
    if (nreads > 40) nreads = 40;
    for (int i = 0; i < nreads; i++) begin
      case ($urandom_range(9))
        0: read_at($urandom_range(tsf_pkg::MAX_LEN - 1));
        1: read_at((span < tsf_pkg::MAX_LEN) ? $urandom_range(span, tsf_pkg::MAX_LEN - 1)
                                             : tsf_pkg::MAX_LEN - 1);
        2: read_at(span - 1);
        default: read_at($urandom_range(span - 1));
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = tsf_pkg::FUNC_LOAD;
    in_ch.sample = '0;
    in_ch.last = 1'b0;
    in_ch.read_index = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    snd_idle = 0;
    rcv_idle = 0;
    items_sent = 0;
    waves_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reads before any waveform, extreme samples, short waveform
    read_at(0);
    read_at(tsf_pkg::MAX_LEN - 1);
    load_sample(32767, 1'b0);
    load_sample(-32768, 1'b0);
    load_sample(0, 1'b0);
    load_sample(-1, 1'b0);
    load_sample(1, 1'b0);
    load_sample(16384, 1'b0);
    load_sample(-16384, 1'b0);
    load_sample(12345, 1'b1);
    read_at(0);
    read_at(3);
    read_at(7);
    read_at(8);
    read_at(tsf_pkg::MAX_LEN - 1);
    // Zero pretrigger and zero normalizer
    set_config(0, 0, 0, 0);
    load_sample(-32768, 1'b0);
    load_sample(32767, 1'b0);
    load_sample(-32768, 1'b0);
    load_sample(100, 1'b1);
    read_at(1);
    read_at(2);
    read_at(3);
    // Single-sample waveform
    set_config(1, 1, 0, 1);
    load_sample(-5, 1'b1);
    read_at(0);
    read_at(1);

    // Random phases with different idling
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 8 : (phase == 1) ? 73 : 0;
      rcv_idle = (phase == 0) ? 73 : (phase == 1) ? 8 : 0;
      case (phase)
        0: set_config(65535, 2047, 2047, 8191);
        1: set_config(1, 1, 0, 1);
        default: set_config(300, 3, 5, 16);
      endcase
      while (items_sent < 25 + (phase + 1) * 575) begin
        if ($urandom_range(9) < 4) random_config();
        run_waveform($urandom_range(1, 40));
      end
    end

    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d waveforms and %0d input items, %0d reads checked,",
             waves_sent, items_sent, reads_checked);
    $display("including extreme settings, zero normalizer and short loads.");
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: trapezoidal_shaping_filter.f
design/tsf_pkg.sv
design/tsf_if.sv
design/tsf_ram.sv
design/tsf_div.sv
design/trapezoidal_shaping_filter.sv
tb/tsf_checker.sv
tb/tb_trapezoidal_shaping_filter.sv
